### rtl/srms_pkg.sv
package srms_pkg;

    localparam int MAX_HALF_WINDOW_DEF = 63;
    localparam int RING_DEPTH_DEF      = 128;
    localparam int QUEUE_DEPTH         = 2;

    localparam int SAMPLE_W = 16;
    localparam int HW_W     = 6;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 38;
    localparam int CNT_W    = 8;
    localparam int PEND_W   = 7;
    localparam int POS_W    = 16;
    localparam int RMS_W    = 16;
    localparam int RAD_W    = 32;
    localparam int SREM_W   = 18;
    localparam int DREM_W   = 9;
    localparam int STEP_W   = 6;

    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = RAD_W / 2;

    localparam logic [HW_W-1:0]  HW_RESET = 6'd31;
    localparam logic [POS_W-1:0] POS_MAX  = 16'hFFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in_item;

    typedef struct packed {
        logic [RMS_W-1:0] rms_value;
        logic [POS_W-1:0] position;
        logic             end_of_trace;
    } t_out_item;

    // What the front hands to the back: raw sample for the ring, its square, trace mark
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SQ_W-1:0]     square;
        logic                last;
    } t_work_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TRIM,
        ST_SUB,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;

    // magnitude keeps 17 bits so that the most negative sample squares to 2^30
    function automatic logic [SQ_W-1:0] square_of(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W:0]     ext;
        logic [SAMPLE_W:0]     mag;
        logic [2*SAMPLE_W+1:0] prod;
        ext  = {s[SAMPLE_W-1], s};
        mag  = s[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - ext) : ext;
        prod = (2*SAMPLE_W+2)'(mag) * (2*SAMPLE_W+2)'(mag);
        return prod[SQ_W-1:0];
    endfunction

endpackage

### rtl/srms_front.sv
module srms_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  srms_pkg::t_in_item     i_in_data,
    output logic                   o_in_stall,
    output logic                   o_push,
    output srms_pkg::t_work_item   o_push_item,
    input  logic                   i_queue_full
);

    logic                 r_valid;
    logic                 n_valid;
    srms_pkg::t_work_item r_item;
    logic                 accept;

    assign o_in_stall  = r_valid && i_queue_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_queue_full;
    assign o_push_item = r_item;
    assign n_valid     = accept || (r_valid && i_queue_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.sample <= i_in_data.sample;
            r_item.square <= srms_pkg::square_of(i_in_data.sample);
            r_item.last   <= i_in_data.last_sample;
        end
    end

endmodule

### rtl/srms_queue.sv
module srms_queue #(
    parameter int Depth = srms_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  srms_pkg::t_work_item i_push_item,
    input  logic                 i_pop,
    output srms_pkg::t_work_item o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    srms_pkg::t_work_item r_mem [Depth];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [CNT_W-1:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == CNT_W'(Depth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

### rtl/srms_back.sv
module srms_back #(
    parameter int MaxHalfWindow = srms_pkg::MAX_HALF_WINDOW_DEF,
    parameter int RingDepth     = srms_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_queue_empty,
    input  srms_pkg::t_work_item                i_head,
    output logic                                o_pop,
    input  logic                                i_cfg_valid,
    input  logic [srms_pkg::HW_W-1:0]           i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output srms_pkg::t_out_item                 o_out_data
);

    localparam int IDX_W = $clog2(RingDepth);
    localparam int WLIM  = (RingDepth - 1) / 2;
    localparam int WCAP  = (MaxHalfWindow < WLIM) ? MaxHalfWindow : WLIM;

    localparam int SUM_W  = srms_pkg::SUM_W;
    localparam int CNT_W  = srms_pkg::CNT_W;
    localparam int PEND_W = srms_pkg::PEND_W;
    localparam int HW_W   = srms_pkg::HW_W;
    localparam int POS_W  = srms_pkg::POS_W;
    localparam int RMS_W  = srms_pkg::RMS_W;
    localparam int RAD_W  = srms_pkg::RAD_W;
    localparam int SREM_W = srms_pkg::SREM_W;
    localparam int DREM_W = srms_pkg::DREM_W;
    localparam int STEP_W = srms_pkg::STEP_W;
    localparam int SQ_W   = srms_pkg::SQ_W;
    localparam int SW     = srms_pkg::SAMPLE_W;

    logic [SW-1:0] r_ring [RingDepth];
    logic [SW-1:0] r_rd_data;

    srms_pkg::t_back_state r_state, n_state;
    logic [IDX_W-1:0]  r_wp, n_wp;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_last, n_last;
    logic [HW_W-1:0]   r_w, n_w;
    logic [HW_W-1:0]   r_hw;
    logic [SUM_W-1:0]  r_dvd, n_dvd;
    logic [DREM_W-1:0] r_drem, n_drem;
    logic [STEP_W-1:0] r_step, n_step;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [RMS_W-1:0]  r_root, n_root;
    logic [SREM_W-1:0] r_srem, n_srem;
    logic              r_out_valid, n_out_valid;
    srms_pkg::t_out_item r_out, n_out;

    logic [HW_W-1:0]   w_eff;
    logic              ring_wr;
    logic              ring_rd;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W:0]    wp_ext;
    logic [IDX_W:0]    cnt_ext;
    logic [IDX_W:0]    idx_full;
    logic [CNT_W-1:0]  pend_ext;
    logic              trim_more;
    logic [SQ_W-1:0]   rd_sq;
    logic [DREM_W-1:0] drem_sh;
    logic [SREM_W-1:0] srem_sh;
    logic [SREM_W-1:0] trial;
    logic              out_free;

    assign w_eff    = (r_hw > HW_W'(WCAP)) ? HW_W'(WCAP) : r_hw;
    assign wp_ext   = {1'b0, r_wp};
    assign cnt_ext  = r_count[IDX_W:0];
    assign idx_full = (wp_ext >= cnt_ext) ? (wp_ext - cnt_ext)
                                          : (wp_ext + (IDX_W+1)'(RingDepth) - cnt_ext);
    assign rd_idx   = idx_full[IDX_W-1:0];
    assign pend_ext = CNT_W'(r_pend);
    assign trim_more = (r_count > pend_ext) && ((r_count - pend_ext) > CNT_W'(r_w));
    assign rd_sq    = srms_pkg::square_of(r_rd_data);
    assign drem_sh  = {r_drem[DREM_W-2:0], r_dvd[SUM_W-1]};
    assign srem_sh  = {r_srem[SREM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial    = {r_root, 2'b01};
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_sum       = r_sum;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_last      = r_last;
        n_w         = r_w;
        n_dvd       = r_dvd;
        n_drem      = r_drem;
        n_step      = r_step;
        n_rad       = r_rad;
        n_root      = r_root;
        n_srem      = r_srem;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        ring_wr     = 1'b0;
        ring_rd     = 1'b0;

        unique case (r_state)
            srms_pkg::ST_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop   = 1'b1;
                    ring_wr = 1'b1;
                    n_wp    = (r_wp == IDX_W'(RingDepth - 1)) ? '0 : r_wp + 1'b1;
                    n_sum   = r_sum + SUM_W'(i_head.square);
                    n_count = r_count + 1'b1;
                    n_pend  = r_pend + 1'b1;
                    n_last  = i_head.last;
                    n_w     = w_eff;
                    n_state = srms_pkg::ST_CHECK;
                end
            end
            srms_pkg::ST_CHECK: begin
                if (r_last ? (r_pend != '0) : (r_pend > PEND_W'(r_w))) begin
                    n_state = srms_pkg::ST_TRIM;
                end else begin
                    if (r_last) begin
                        n_sum   = '0;
                        n_count = '0;
                        n_pend  = '0;
                        n_pos   = '0;
                    end
                    n_state = srms_pkg::ST_IDLE;
                end
            end
            srms_pkg::ST_TRIM: begin
                // oldest sample drops out while the window reaches past w behind the output
                if (trim_more) begin
                    ring_rd = 1'b1;
                    n_state = srms_pkg::ST_SUB;
                end else if (r_count != '0 && r_sum != '0) begin
                    n_dvd   = r_sum;
                    n_drem  = '0;
                    n_step  = '0;
                    n_state = srms_pkg::ST_DIV;
                end else begin
                    n_root  = '0;
                    n_state = srms_pkg::ST_OUT;
                end
            end
            srms_pkg::ST_SUB: begin
                n_sum   = (r_sum >= SUM_W'(rd_sq)) ? r_sum - SUM_W'(rd_sq) : '0;
                n_count = r_count - 1'b1;
                n_state = srms_pkg::ST_TRIM;
            end
            srms_pkg::ST_DIV: begin
                if (drem_sh >= DREM_W'(r_count)) begin
                    n_drem = drem_sh - DREM_W'(r_count);
                    n_dvd  = {r_dvd[SUM_W-2:0], 1'b1};
                end else begin
                    n_drem = drem_sh;
                    n_dvd  = {r_dvd[SUM_W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(srms_pkg::DIV_STEPS - 1)) begin
                    // quotient is below 2^31, so the low word is the whole mean
                    n_rad   = n_dvd[RAD_W-1:0];
                    n_root  = '0;
                    n_srem  = '0;
                    n_step  = '0;
                    n_state = srms_pkg::ST_SQRT;
                end
            end
            srms_pkg::ST_SQRT: begin
                if (srem_sh >= trial) begin
                    n_srem = srem_sh - trial;
                    n_root = {r_root[RMS_W-2:0], 1'b1};
                end else begin
                    n_srem = srem_sh;
                    n_root = {r_root[RMS_W-2:0], 1'b0};
                end
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(srms_pkg::SQRT_STEPS - 1)) begin
                    n_state = srms_pkg::ST_OUT;
                end
            end
            srms_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.rms_value    = r_root;
                    n_out.position     = r_pos;
                    n_out.end_of_trace = r_last && (r_pend == PEND_W'(1));
                    n_pend             = (r_pend != '0) ? r_pend - 1'b1 : r_pend;
                    n_pos              = (r_pos != srms_pkg::POS_MAX) ? r_pos + 1'b1 : r_pos;
                    n_state            = srms_pkg::ST_CHECK;
                end
            end
            default: begin
                n_state = srms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srms_pkg::ST_IDLE;
            r_wp        <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_pend      <= '0;
            r_pos       <= '0;
            r_last      <= 1'b0;
            r_w         <= '0;
            r_hw        <= srms_pkg::HW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_pos       <= n_pos;
            r_last      <= n_last;
            r_w         <= n_w;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_hw <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_drem <= n_drem;
        r_step <= n_step;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_srem <= n_srem;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[r_wp] <= i_head.sample;
        end
        if (ring_rd) begin
            r_rd_data <= r_ring[rd_idx];
        end
    end

endmodule

### rtl/sliding_rms_agc_envelope_core.sv
// Flow: the front registers each sample with its square, the queue holds it, and the
// back pops it while idle; each result then drops the leaving samples one ring read at a
// time, runs the 1-bit-a-cycle divide and the square root; a zero result skips both.
// Throughput is set by the shared divide/root unit: one result at a time.
// Reset (synchronous, i_rst_n low) clears sums, counts, position and pointers and sets
// the half width to 31; the sample ring holds stale data, which is never read.
module sliding_rms_agc_envelope_core #(
    parameter int MaxHalfWindow = srms_pkg::MAX_HALF_WINDOW_DEF,
    parameter int RingDepth     = srms_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  srms_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output srms_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [srms_pkg::HW_W-1:0]   i_cfg_data
);

    logic                 push;
    srms_pkg::t_work_item push_item;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 pop;
    srms_pkg::t_work_item head;

    assign o_cfg_ready = 1'b1;

    srms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_item  (push_item),
        .i_queue_full (queue_full)
    );

    srms_queue #(
        .Depth (srms_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (queue_full),
        .o_empty     (queue_empty)
    );

    srms_back #(
        .MaxHalfWindow (MaxHalfWindow),
        .RingDepth     (RingDepth)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

### rtl/srms_checker.sv
module srms_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input srms_pkg::t_out_item o_out_data
);

    logic [srms_pkg::POS_W-1:0] r_exp_pos;
    logic                       out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    // expected position of the next result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
        end else if (out_xfer) begin
            if (o_out_data.end_of_trace) begin
                r_exp_pos <= '0;
            end else if (o_out_data.position != srms_pkg::POS_MAX) begin
                r_exp_pos <= o_out_data.position + 1'b1;
            end
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    a_position_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> o_out_data.position == r_exp_pos)
        else $error("result position out of order");

    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.rms_value <= 16'd32768)
        else $error("rms value above full scale");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_rms_agc_envelope_core srms_checker u_srms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### test/tb_sliding_rms_agc_envelope_core.sv
module tb_sliding_rms_agc_envelope_core;

    localparam int RING_N = 128;

    // Mirror of the block's trace state; predicts the RMS results of each sample
    class rms_scoreboard;
        logic [15:0]  ring [RING_N];
        logic [37:0]  sq_sum;
        int unsigned  win_cnt;
        int unsigned  pend;
        int unsigned  out_pos;
        int unsigned  wr_ptr;
        logic [5:0]   half_w;
        srms_pkg::t_out_item awaited[$];
        int           n_err;

        function new();
            sq_sum = '0;
            win_cnt = 0;
            pend = 0;
            out_pos = 0;
            wr_ptr = 0;
            half_w = 6'd31;
            n_err = 0;
        endfunction

        function logic [37:0] sq(input logic [15:0] raw);
            logic signed [16:0] v;
            logic [16:0] m;
            v = {raw[15], raw};
            m = v < 0 ? -v : v;
            return 38'(m) * 38'(m);
        endfunction

        function logic [15:0] isqrt(input logic [37:0] x);
            logic [63:0] r;
            logic [63:0] b;
            logic [63:0] xx;
            r = 0;
            xx = 64'(x);
            b = 64'd1 << 62;
            while (b > xx) b = b >> 2;
            while (b != 0) begin
                if (xx >= r + b) begin
                    xx = xx - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (r > 64'hFFFF) r = 64'hFFFF;
            return r[15:0];
        endfunction

        function void emit_rms(input int unsigned w, input bit eot);
            srms_pkg::t_out_item o;
            logic [37:0] s;
            int unsigned idx;
            while (win_cnt > pend && win_cnt - pend > w) begin
                idx = (wr_ptr + RING_N - (win_cnt % RING_N)) % RING_N;
                s = sq(ring[idx]);
                sq_sum = sq_sum >= s ? sq_sum - s : '0;
                win_cnt--;
            end
            o.rms_value = '0;
            if (win_cnt != 0 && sq_sum != 0) o.rms_value = isqrt(sq_sum / win_cnt);
            o.position = out_pos[15:0];
            o.end_of_trace = eot;
            awaited.push_back(o);
            if (pend != 0) pend--;
            if (out_pos < 16'hFFFF) out_pos++;
        endfunction

        function void note_sample(input srms_pkg::t_in_item it);
            int unsigned w;
            int n;
            w = half_w;
            n = 0;
            ring[wr_ptr] = it.sample;
            wr_ptr = (wr_ptr + 1) % RING_N;
            sq_sum += sq(it.sample);
            win_cnt++;
            pend++;
            if (it.last_sample) begin
                while (pend > 0 && n < 64) begin
                    emit_rms(w, pend == 1);
                    n++;
                end
                sq_sum = '0;
                win_cnt = 0;
                pend = 0;
                out_pos = 0;
            end else begin
                while (pend > w && n < 64) begin
                    emit_rms(w, 1'b0);
                    n++;
                end
            end
        endfunction

        function void check_rms(input srms_pkg::t_out_item got);
            srms_pkg::t_out_item e;
            if (awaited.size() == 0) begin
                report_err("result with nothing awaited");
                return;
            end
            e = awaited.pop_front();
            if (got.rms_value !== e.rms_value)
                report_err($sformatf("rms %0d, want %0d at pos %0d",
                    got.rms_value, e.rms_value, e.position));
            if (got.position !== e.position)
                report_err($sformatf("position %0d, want %0d", got.position, e.position));
            if (got.end_of_trace !== e.end_of_trace)
                report_err($sformatf("end mark %0b, want %0b at pos %0d",
                    got.end_of_trace, e.end_of_trace, e.position));
        endfunction

        function void report_err(input string msg);
            $display("mismatch: %s", msg);
            n_err++;
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    srms_pkg::t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    srms_pkg::t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [srms_pkg::HW_W-1:0] i_cfg_data = '0;

    rms_scoreboard sb;
    int  hold_off = 0;
    bit  draining = 1'b0;

    sliding_rms_agc_envelope_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        int gap;
        sb = new();
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_rms(o_out_data);
            if (hold_off > 0) begin
                hold_off--;
                i_out_stall <= 1'b1;
            end else if (!i_out_stall && o_out_valid && !draining
                         && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                hold_off = gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // valid stays up after a transfer until the next item or the idle wait drops it
    task automatic send_sample(input logic [15:0] s, input bit last);
        int gap;
        srms_pkg::t_in_item it;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.sample = s;
        it.last_sample = last;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(it);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_half_width(input logic [5:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.half_w = w;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_trace(input int len);
        for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset width, extremes, zero window, single-sample and short traces
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h8000, 1'b1);
        wait_idle();
        write_half_width(6'd0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_idle();
        write_half_width(6'd63);
        send_trace(6);
        wait_idle();
        write_half_width(6'd2);
        send_trace(8);
        wait_idle();

        // long stall on the output while the input keeps offering
        write_half_width(6'd1);
        hold_off = 400;
        send_trace(30);
        wait_idle();

        sent = 53;
        while (sent < 430) begin
            case ($urandom_range(0, 4))
                0: write_half_width(6'($urandom_range(0, 3)));
                1: write_half_width(6'($urandom_range(4, 12)));
                2: write_half_width(6'd63);
                3: write_half_width(6'($urandom));
                default: write_half_width(6'd0);
            endcase
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
            send_trace(len);
            sent += len;
            wait_idle();
        end

        draining = 1'b1;
        wait_idle();
        if (sb.n_err == 0 && sb.awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
